[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Every macro samples on clk and is
// quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle
`define RVU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define RVU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RVU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rvu_pkg.sv]
package rvu_pkg;

	// Fixed-point formats
	localparam int FRAC_BITS  = 14;
	localparam int RATIO_FRAC = 13;
	localparam int RATIO_W    = 16;
	localparam int ONE_Q14    = 1 << FRAC_BITS;

	// Queue status seen by the front and back ends
	typedef struct packed {
		logic can_push;
		logic can_pop;
	} fifo_stat_t;

	// Cosine register: wide enough for the component range and for 1.0
	function automatic int cos_width(input int cw);
		return (cw > 16) ? cw : 16;
	endfunction

	// Queue entry: ratio, cosine, three direction and three normal components
	function automatic int queue_width(input int cw);
		return RATIO_W + cos_width(cw) + 6 * cw;
	endfunction

endpackage

[rtl/core/rvu_in_if.sv]
interface rvu_in_if #(parameter int COMP_WIDTH = 16);
	import rvu_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] dir_x;
	logic signed [COMP_WIDTH-1:0] dir_y;
	logic signed [COMP_WIDTH-1:0] dir_z;
	logic signed [COMP_WIDTH-1:0] norm_x;
	logic signed [COMP_WIDTH-1:0] norm_y;
	logic signed [COMP_WIDTH-1:0] norm_z;
	logic [RATIO_W-1:0]           index_ratio;

	modport source (
		output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio,
		input  ready
	);

	modport sink (
		input  valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio,
		output ready
	);

endinterface

[rtl/core/rvu_out_if.sv]
interface rvu_out_if #(parameter int COMP_WIDTH = 16);

	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] out_x;
	logic signed [COMP_WIDTH-1:0] out_y;
	logic signed [COMP_WIDTH-1:0] out_z;
	logic                         total_reflection;

	modport source (
		output valid, out_x, out_y, out_z, total_reflection,
		input  ready
	);

	modport sink (
		input  valid, out_x, out_y, out_z, total_reflection,
		output ready
	);

endinterface

[rtl/core/refraction_vector_unit.sv]
// Channel     Role    Handshake      Payload
// incident    sink    valid/ready    dir_x/y/z, norm_x/y/z, index_ratio
// refracted   source  valid/ready    out_x/y/z, total_reflection
//
// One transaction per cycle sustained while refracted.ready stays high; the path
// from acceptance to a valid result is 2 front stages, the queue, 12 back stages
// (5 of them are the square root, three result bits per stage).
// arst_n clears all valids and queue pointers; no clearing pass is needed.
// A stalled refracted channel freezes the back pipe; the 4-entry queue then
// fills before incident.ready drops.
module refraction_vector_unit #(
	parameter int COMP_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rvu_in_if.sink    incident,
	rvu_out_if.source refracted
);
	import rvu_pkg::*;

	localparam int QW = queue_width(COMP_WIDTH);

	logic          push;
	logic          pop;
	logic [QW-1:0] push_data;
	logic [QW-1:0] pop_data;
	fifo_stat_t    qstat;

	// accept, dot product and cosine
	rvu_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.incident  (incident),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	rvu_fifo #(.DATA_W(QW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (qstat)
	);

	// perpendicular part, square root, parallel part
	rvu_back #(.COMP_WIDTH(COMP_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_data  (pop_data),
		.pop       (pop),
		.refracted (refracted)
	);

endmodule

[rtl/core/rvu_fifo.sv]
`include "assert_macros.svh"

module rvu_fifo #(
	parameter int DATA_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [DATA_W-1:0]   push_data,
	input  logic                pop,
	output logic [DATA_W-1:0]   pop_data,
	output rvu_pkg::fifo_stat_t stat
);
	import rvu_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNTW  = AW + 1;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_q;
	logic [CNTW-1:0]   cnt_q;

	// status and first-word-fall-through read
	assign stat.can_push = (cnt_q != CNTW'(DEPTH));
	assign stat.can_pop  = (cnt_q != '0);
	assign pop_data      = mem_q[rd_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop)  rd_q <= rd_q + AW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNTW'(1);
				2'b01:   cnt_q <= cnt_q - CNTW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	`RVU_ASSERT(a_fifo_cnt_range, cnt_q <= CNTW'(DEPTH), "queue count beyond depth")
	`RVU_ASSERT_IMPL(a_fifo_no_overflow, push, stat.can_push, "push into full queue")

endmodule

[rtl/core/rvu_front.sv]
`include "assert_macros.svh"

module rvu_front #(
	parameter int COMP_WIDTH = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	rvu_in_if.sink                                       incident,
	input  rvu_pkg::fifo_stat_t                          qstat,
	output logic                                         push,
	output logic [rvu_pkg::queue_width(COMP_WIDTH)-1:0]  push_data
);
	import rvu_pkg::*;

	localparam int CW   = COMP_WIDTH;
	localparam int PRW  = 2 * CW;
	localparam int SUMW = PRW - FRAC_BITS + 2;
	localparam int NEGW = (SUMW + 1 > 17) ? SUMW + 1 : 17;
	localparam int COSW = cos_width(CW);
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic                  vld_s1, vld_s2;
	logic                  rdy_s1, rdy_s2;
	logic signed [CW-1:0]  d_s1 [3];
	logic signed [CW-1:0]  n_s1 [3];
	logic [RATIO_W-1:0]    eta_s1;
	logic signed [PRW-1:0] dn_s1 [3];
	logic signed [CW-1:0]  d_s2 [3];
	logic signed [CW-1:0]  n_s2 [3];
	logic [RATIO_W-1:0]    eta_s2;
	logic signed [COSW-1:0] cos_s2;
	logic signed [SUMW-1:0] dot;
	logic signed [NEGW-1:0] negd;
	logic signed [COSW-1:0] cos_c;

	// handshake: each stage moves when the one after it has room
	assign rdy_s2         = !vld_s2 || qstat.can_push;
	assign rdy_s1         = !vld_s1 || rdy_s2;
	assign incident.ready = rdy_s1;
	assign push           = vld_s2 && qstat.can_push;
	assign push_data      = {eta_s2, cos_s2, d_s2[2], d_s2[1], d_s2[0],
		n_s2[2], n_s2[1], n_s2[0]};

	// cosine = -dot(d, n), capped at 1.0, floored at the component minimum
	always_comb begin
		dot = SUMW'(dn_s1[0] >>> FRAC_BITS) + SUMW'(dn_s1[1] >>> FRAC_BITS)
			+ SUMW'(dn_s1[2] >>> FRAC_BITS);
		negd = -NEGW'(dot);
		if (negd > NEGW'(ONE_Q14)) begin
			cos_c = COSW'(ONE_Q14);
		end else if (negd < NEGW'(CMIN)) begin
			cos_c = COSW'(CMIN);
		end else begin
			cos_c = COSW'(negd);
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= incident.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	// stage payloads: products on entry, cosine on the way to the queue
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			d_s1[0]  <= incident.dir_x;
			d_s1[1]  <= incident.dir_y;
			d_s1[2]  <= incident.dir_z;
			n_s1[0]  <= incident.norm_x;
			n_s1[1]  <= incident.norm_y;
			n_s1[2]  <= incident.norm_z;
			eta_s1   <= incident.index_ratio;
			dn_s1[0] <= PRW'(incident.dir_x) * PRW'(incident.norm_x);
			dn_s1[1] <= PRW'(incident.dir_y) * PRW'(incident.norm_y);
			dn_s1[2] <= PRW'(incident.dir_z) * PRW'(incident.norm_z);
		end
		if (rdy_s2) begin
			d_s2   <= d_s1;
			n_s2   <= n_s1;
			eta_s2 <= eta_s1;
			cos_s2 <= cos_c;
		end
	end

	`RVU_ASSERT_NEXT(a_front_hold, vld_s2 && !qstat.can_push, vld_s2, "front dropped a stalled item")

endmodule

[rtl/core/rvu_back.sv]
`include "assert_macros.svh"

module rvu_back #(
	parameter int COMP_WIDTH = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  rvu_pkg::fifo_stat_t                          qstat,
	input  logic [rvu_pkg::queue_width(COMP_WIDTH)-1:0]  pop_data,
	output logic                                         pop,
	rvu_out_if.source                                    refracted
);
	import rvu_pkg::*;

	localparam int CW    = COMP_WIDTH;
	localparam int COSW  = cos_width(CW);
	localparam int QW    = queue_width(CW);
	localparam int CPW   = COSW + CW;
	localparam int SCW   = CPW - FRAC_BITS;
	localparam int TW0   = ((CW > SCW) ? CW : SCW) + 1;
	localparam int TW    = CW + 1;
	localparam int EPW   = TW + RATIO_W + 1;
	localparam int PW    = EPW - RATIO_FRAC;
	localparam int MW    = (PW > 17) ? PW : 17;
	localparam int SQW   = 31;
	localparam int LW    = 32;
	localparam int XW    = 29;
	localparam int RPW   = CW + 16;
	localparam int NPW   = RPW + 1;
	localparam int PARW  = NPW - FRAC_BITS;
	localparam int OSW   = PW + 1;
	localparam int RAD_ONE   = ONE_Q14 * ONE_Q14;
	localparam int SQ_STEPS  = 15;
	localparam int STEPS_PER = 3;
	localparam int SQ_ST     = SQ_STEPS / STEPS_PER;
	localparam logic signed [CW:0]   SMIN = {1'b1, {CW{1'b0}}};
	localparam logic signed [CW:0]   SMAX = {1'b0, {CW{1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

	// one digit-recurrence square root state
	typedef struct packed {
		logic [29:0] bits;
		logic [16:0] rem;
		logic [14:0] root;
	} sqrt_t;

	function automatic sqrt_t sqrt_step(input sqrt_t s);
		logic [18:0] sh;
		logic [16:0] trial;
		sqrt_t       r;
		sh     = {s.rem, s.bits[29:28]};
		trial  = {s.root, 2'b01};
		r.bits = {s.bits[27:0], 2'b00};
		if (sh >= {2'b00, trial}) begin
			r.rem  = 17'(sh - {2'b00, trial});
			r.root = {s.root[13:0], 1'b1};
		end else begin
			r.rem  = sh[16:0];
			r.root = {s.root[13:0], 1'b0};
		end
		return r;
	endfunction

	logic adv;

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s11, vld_s12;
	logic [SQ_ST-1:0]       vld_sx;

	logic signed [COSW-1:0] cos_in;
	logic signed [CW-1:0]   d_in [3];
	logic signed [CW-1:0]   n_in [3];
	logic [RATIO_W-1:0]     eta_in;

	logic signed [CPW-1:0]  cn_s1 [3];
	logic signed [CW-1:0]   d_s1 [3];
	logic signed [CW-1:0]   n_s1 [3];
	logic [RATIO_W-1:0]     eta_s1;

	logic signed [TW0-1:0]  t_wide [3];
	logic signed [TW-1:0]   t_c [3];
	logic signed [TW-1:0]   t_s2 [3];
	logic signed [CW-1:0]   n_s2 [3];
	logic [RATIO_W-1:0]     eta_s2;

	logic signed [EPW-1:0]  ep_s3 [3];
	logic signed [CW-1:0]   n_s3 [3];

	logic signed [PW-1:0]   perp_c [3];
	logic signed [MW-1:0]   pm [3];
	logic signed [16:0]     pc [3];
	logic signed [33:0]     sqf [3];
	logic [SQW-1:0]         sq_s4 [3];
	logic signed [PW-1:0]   perp_s4 [3];
	logic signed [CW-1:0]   n_s4 [3];

	logic [LW-1:0]          lensq;
	logic                   tir_c;
	logic [XW-1:0]          x_c;
	logic [XW-1:0]          x_s5;
	logic                   tir_s5;
	logic signed [PW-1:0]   perp_s5 [3];
	logic signed [CW-1:0]   n_s5 [3];

	// square root stages s6..s10
	sqrt_t                  sq_in [SQ_ST];
	sqrt_t                  sq_nx [SQ_ST];
	sqrt_t                  sq_sx [SQ_ST];
	logic signed [PW-1:0]   perp_sx [SQ_ST][3];
	logic signed [CW-1:0]   n_sx [SQ_ST][3];
	logic [SQ_ST-1:0]       tir_sx;

	logic signed [RPW-1:0]  rn_s11 [3];
	logic signed [PW-1:0]   perp_s11 [3];
	logic                   tir_s11;

	logic signed [NPW-1:0]  negp [3];
	logic signed [PARW-1:0] par [3];
	logic signed [OSW-1:0]  osum [3];
	logic signed [CW-1:0]   o_c [3];
	logic signed [CW-1:0]   o_s12 [3];
	logic                   tir_s12;

	// whole back pipe advances while the output register is free or drained
	assign adv = !vld_s12 || refracted.ready;
	assign pop = adv && qstat.can_pop;

	assign refracted.valid            = vld_s12;
	assign refracted.out_x            = o_s12[0];
	assign refracted.out_y            = o_s12[1];
	assign refracted.out_z            = o_s12[2];
	assign refracted.total_reflection = tir_s12;

	// queue entry unpack
	assign eta_in  = pop_data[QW-1 -: RATIO_W];
	assign cos_in  = $signed(pop_data[QW-RATIO_W-1 -: COSW]);
	assign d_in[2] = $signed(pop_data[6*CW-1 -: CW]);
	assign d_in[1] = $signed(pop_data[5*CW-1 -: CW]);
	assign d_in[0] = $signed(pop_data[4*CW-1 -: CW]);
	assign n_in[2] = $signed(pop_data[3*CW-1 -: CW]);
	assign n_in[1] = $signed(pop_data[2*CW-1 -: CW]);
	assign n_in[0] = $signed(pop_data[CW-1:0]);

	// d + cos*n, saturated one bit beyond the component range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_wide[i] = TW0'(d_s1[i]) + TW0'(cn_s1[i] >>> FRAC_BITS);
			if (t_wide[i] > TW0'(SMAX)) begin
				t_c[i] = SMAX;
			end else if (t_wide[i] < TW0'(SMIN)) begin
				t_c[i] = SMIN;
			end else begin
				t_c[i] = TW'(t_wide[i]);
			end
		end
	end

	// perpendicular part and its clamped squares
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			perp_c[i] = PW'(ep_s3[i] >>> RATIO_FRAC);
			pm[i]     = MW'(perp_c[i]);
			if (pm[i] > MW'(2 * ONE_Q14)) begin
				pc[i] = 17'(2 * ONE_Q14);
			end else if (pm[i] < -MW'(2 * ONE_Q14)) begin
				pc[i] = -17'(2 * ONE_Q14);
			end else begin
				pc[i] = 17'(pm[i]);
			end
			sqf[i] = 34'(pc[i]) * 34'(pc[i]);
		end
	end

	// radicand, clamped to zero on total internal reflection
	always_comb begin
		lensq = LW'(sq_s4[0]) + LW'(sq_s4[1]) + LW'(sq_s4[2]);
		tir_c = lensq > LW'(RAD_ONE);
		x_c   = tir_c ? '0 : XW'(LW'(RAD_ONE) - lensq);
	end

	// square root, three result bits per stage
	always_comb begin
		for (int k = 0; k < SQ_ST; k++) begin
			if (k == 0) begin
				sq_in[k].bits = {1'b0, x_s5};
				sq_in[k].rem  = '0;
				sq_in[k].root = '0;
			end else begin
				sq_in[k] = sq_sx[k-1];
			end
			sq_nx[k] = sq_in[k];
			for (int j = 0; j < STEPS_PER; j++) begin
				sq_nx[k] = sqrt_step(sq_nx[k]);
			end
		end
	end

	// perp minus root*n, saturated
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			negp[i] = -NPW'(rn_s11[i]);
			par[i]  = PARW'(negp[i] >>> FRAC_BITS);
			osum[i] = OSW'(perp_s11[i]) + OSW'(par[i]);
			if (osum[i] > OSW'(CMAX)) begin
				o_c[i] = CMAX;
			end else if (osum[i] < OSW'(CMIN)) begin
				o_c[i] = CMIN;
			end else begin
				o_c[i] = CW'(osum[i]);
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_sx  <= '0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= qstat.can_pop;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_sx  <= {vld_sx[SQ_ST-2:0], vld_s5};
			vld_s11 <= vld_sx[SQ_ST-1];
			vld_s12 <= vld_s11;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cn_s1[i] <= CPW'(cos_in) * CPW'(n_in[i]);
				ep_s3[i] <= EPW'($signed({1'b0, eta_s2})) * EPW'(t_s2[i]);
				sq_s4[i] <= SQW'(sqf[i]);
				rn_s11[i] <= RPW'($signed({1'b0, sq_sx[SQ_ST-1].root})) * RPW'(n_sx[SQ_ST-1][i]);
			end
			d_s1     <= d_in;
			n_s1     <= n_in;
			eta_s1   <= eta_in;

			t_s2     <= t_c;
			n_s2     <= n_s1;
			eta_s2   <= eta_s1;

			n_s3     <= n_s2;

			perp_s4  <= perp_c;
			n_s4     <= n_s3;

			x_s5     <= x_c;
			tir_s5   <= tir_c;
			perp_s5  <= perp_s4;
			n_s5     <= n_s4;

			sq_sx[0]   <= sq_nx[0];
			perp_sx[0] <= perp_s5;
			n_sx[0]    <= n_s5;
			tir_sx[0]  <= tir_s5;
			for (int k = 1; k < SQ_ST; k++) begin
				sq_sx[k]   <= sq_nx[k];
				perp_sx[k] <= perp_sx[k-1];
				n_sx[k]    <= n_sx[k-1];
				tir_sx[k]  <= tir_sx[k-1];
			end

			perp_s11 <= perp_sx[SQ_ST-1];
			tir_s11  <= tir_sx[SQ_ST-1];

			o_s12    <= o_c;
			tir_s12  <= tir_s11;
		end
	end

	`RVU_ASSERT_IMPL(a_tir_zero_rad, vld_s5 && tir_s5, x_s5 == '0, "reflection with nonzero radicand")
	`RVU_ASSERT_IMPL(a_root_range, vld_sx[SQ_ST-1], sq_sx[SQ_ST-1].root <= 15'(ONE_Q14), "root above 1.0")

endmodule
